FILE: hw/rtl/cfr_pkg.sv
// ============================================================================
// cfr_pkg: shared types for the chunked frame reassembler
// Word formats on the ports, the command passed from the classifier to the
// executor, and the result status codes.
// ============================================================================
package cfr_pkg;

    localparam int unsigned ADDR_W  = 15;
    localparam int unsigned FRAME_W = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned VB_W    = 11;
    localparam int unsigned WPOS_W  = 7;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned LEN_W   = 19;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_DROP   = 2'd1,
        ST_DONE   = 2'd2,
        ST_READ   = 2'd3
    } t_status;

    typedef struct packed {
        t_op                 operation;
        logic [FRAME_W-1:0]  frame_number;
        logic [COUNT_W-1:0]  chunk_position;
        logic [COUNT_W-1:0]  chunks_in_frame;
        logic [VB_W-1:0]     valid_bytes;
        logic [WPOS_W-1:0]   word_position;
        logic [WORD_W-1:0]   payload_word;
        logic                chunk_end;
        logic [ADDR_W-1:0]   read_word_address;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic [FRAME_W-1:0]  done_frame;
        logic [LEN_W-1:0]    frame_length;
        logic [WORD_W-1:0]   read_word;
    } t_result;

    // One classified word on its way to the executor.
    typedef struct packed {
        t_status             status;
        logic                store;
        logic [ADDR_W-1:0]   addr;
        logic [WORD_W-1:0]   data;
        logic [FRAME_W-1:0]  done_frame;
        logic [COUNT_W-1:0]  limit_m1;
        logic [VB_W-1:0]     last_bytes;
        logic                rd_in_range;
    } t_cmd;

endpackage

FILE: hw/rtl/chunked_frame_reassembler.sv
// ============================================================================
// chunked_frame_reassembler: frame reassembly from fixed-size chunks
// Tracks the chunks of the current frame, stores their words in a frame
// buffer, reports completed frames and serves buffer reads.
// ============================================================================
// The block takes one word per clock on the push/full side, while the queue
// is not full, and returns one result per word on the empty/pop side, in
// order. A classifier checks each word against the current frame in the
// cycle it is accepted: the first word of a chunk (word position zero) may
// start a new frame, which clears the received-chunk bitmap at once, and
// then decides whether the chunk is taken. Its decision travels through a
// two-entry command queue to the executor, which writes the masked word into
// the frame buffer, or reads a buffer word, and holds the result in an
// output register. A result passes a queue slot and the output register;
// a read returns the buffer contents including every write accepted before
// it. Sustained throughput is one word per cycle while results are popped
// each cycle, limited by the single buffer port, which serves one write or
// one read each cycle. Reading a buffer word that was never written since
// reset returns undefined data. The bitmap has one flip-flop per chunk, so
// MAX_CHUNKS sets its size; the buffer holds MAX_CHUNKS times the chunk
// size in words, capped at the 15-bit read address range.
module chunked_frame_reassembler #(
    parameter int unsigned MAX_CHUNKS = 256,
    parameter int unsigned CHUNK_SIZE = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  cfr_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output cfr_pkg::t_result o_result
);
    import cfr_pkg::*;

    t_cmd w_front_cmd;
    t_cmd w_head_cmd;
    logic w_cmd_empty;
    logic w_cmd_pop;
    logic w_accept;

    // A word is taken whenever the command queue has room.
    assign w_accept = push && !full;

    cfr_front #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .CHUNK_SIZE (CHUNK_SIZE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (i_item),
        .o_cmd   (w_front_cmd)
    );

    cfr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_empty (w_cmd_empty),
        .o_cmd   (w_head_cmd)
    );

    // The executor drains the queue whenever its output register is free or
    // being emptied in the same cycle.
    cfr_back #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .CHUNK_SIZE (CHUNK_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_head_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    // Frame id and length are only reported with a completion.
    a_done_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_DONE)
        |-> (o_result.done_frame == '0 && o_result.frame_length == '0))
        else $error("frame id or length set on a non-completion result");

    // Buffer data only shows up on read results.
    a_read_word_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_READ) |-> (o_result.read_word == '0))
        else $error("read data on a non-read result");

    // A full queue always holds a command for the executor.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !w_cmd_empty)
        else $error("command queue full and empty at once");

    // With the output register free, a queued command moves on at once.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_cmd_empty && empty) |=> !empty)
        else $error("queued command not executed");

endmodule

FILE: hw/rtl/cfr_ram.sv
// ============================================================================
// cfr_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data that holds
// until the next read.
// ============================================================================
module cfr_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/cfr_front.sv
// ============================================================================
// cfr_front: word classifier
// Keeps the frame tracking state, decides for each word whether it is
// stored, dropped, completes the frame or is a buffer read.
// ============================================================================
module cfr_front #(
    parameter int unsigned MAX_CHUNKS = 256,
    parameter int unsigned CHUNK_SIZE = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cfr_pkg::t_item i_item,
    output cfr_pkg::t_cmd  o_cmd
);
    import cfr_pkg::*;

    localparam int unsigned CHUNK_WORDS = (CHUNK_SIZE + 7) / 8;
    localparam int unsigned BUF_WORDS   = MAX_CHUNKS * CHUNK_WORDS;
    localparam int unsigned MEM_DEPTH   = (BUF_WORDS < (1 << ADDR_W)) ? BUF_WORDS
                                                                       : (1 << ADDR_W);
    localparam int unsigned MIW         = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int unsigned TW          = $clog2(MAX_CHUNKS + 1);

    logic [FRAME_W-1:0]    r_cur,   n_cur;
    logic [COUNT_W-1:0]    r_limit, n_limit;
    logic [MAX_CHUNKS-1:0] r_map,   n_map;
    logic [TW-1:0]         r_total, n_total;
    logic [VB_W-1:0]       r_final, n_final;
    logic                  r_acc,   n_acc;

    logic                  w_is_read;
    logic                  w_first;
    logic                  w_new;
    logic [FRAME_W-1:0]    w_cur;
    logic [COUNT_W-1:0]    w_limit;
    logic [MAX_CHUNKS-1:0] w_map;
    logic [TW-1:0]         w_total;
    logic [TW-1:0]         w_total_next;
    logic [MIW-1:0]        w_idx;
    logic                  w_ok;
    logic                  w_acc;
    logic                  w_take;
    logic [VB_W-1:0]       w_vb;
    logic [WORD_W-1:0]     w_mask;
    logic [31:0]           w_addr;
    logic                  w_store;
    logic                  w_is_final;
    logic [VB_W-1:0]       w_final_next;
    logic                  w_done;

    assign w_is_read = (i_item.operation == OP_READ);
    assign w_first   = (i_item.word_position == '0);
    assign w_new     = w_first && (i_item.frame_number != r_cur);
    assign w_cur     = w_first ? i_item.frame_number : r_cur;
    assign w_limit   = w_new ? i_item.chunks_in_frame : r_limit;
    assign w_map     = w_new ? '0 : r_map;
    assign w_total   = w_new ? '0 : r_total;
    assign w_idx     = i_item.chunk_position[MIW-1:0];

    assign w_ok = (32'(i_item.chunk_position) < 32'(w_limit))
               && (32'(i_item.chunk_position) < MAX_CHUNKS)
               && !w_map[w_idx];
    assign w_acc  = w_first ? w_ok : r_acc;
    assign w_take = w_acc && (i_item.frame_number == w_cur) && w_ok;

    assign w_vb = (32'(i_item.valid_bytes) > CHUNK_SIZE) ? VB_W'(CHUNK_SIZE)
                                                         : i_item.valid_bytes;

    // A byte survives when it lies below the valid byte count of the chunk.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_mask[b*8 +: 8] = (32'(w_vb) > (32'(i_item.word_position) * 8 + 32'(b)))
                             ? 8'hFF : 8'h00;
        end
    end

    assign w_addr  = 32'(i_item.chunk_position) * CHUNK_WORDS
                   + 32'(i_item.word_position);
    assign w_store = w_take && (32'(i_item.word_position) < CHUNK_WORDS)
                  && (w_addr < MEM_DEPTH);

    // Only a chunk word can complete a frame; a read never does.
    assign w_total_next = w_total + TW'(1);
    assign w_is_final   = (32'(i_item.chunk_position) == 32'(w_limit) - 32'd1);
    assign w_final_next = w_is_final ? w_vb : r_final;
    assign w_done       = !w_is_read && w_take && i_item.chunk_end
                       && (32'(w_total_next) == 32'(w_limit));

    always_comb begin
        o_cmd.store       = !w_is_read && w_store;
        o_cmd.addr        = w_is_read ? i_item.read_word_address : w_addr[ADDR_W-1:0];
        o_cmd.data        = i_item.payload_word & w_mask;
        o_cmd.done_frame  = w_done ? w_cur : '0;
        o_cmd.limit_m1    = w_limit - COUNT_W'(1);
        o_cmd.last_bytes  = w_final_next;
        o_cmd.rd_in_range = 32'(i_item.read_word_address) < BUF_WORDS;
        priority if (w_is_read) begin
            o_cmd.status = ST_READ;
        end else if (!w_take) begin
            o_cmd.status = ST_DROP;
        end else if (w_done) begin
            o_cmd.status = ST_DONE;
        end else begin
            o_cmd.status = ST_ACCEPT;
        end
    end

    always_comb begin
        n_cur   = r_cur;
        n_limit = r_limit;
        n_map   = r_map;
        n_total = r_total;
        n_final = r_final;
        n_acc   = r_acc;
        if (i_valid && !w_is_read) begin
            n_cur   = w_cur;
            n_limit = w_limit;
            n_map   = w_map;
            n_total = w_total;
            n_acc   = w_acc;
            if (w_take && i_item.chunk_end) begin
                n_map[w_idx] = 1'b1;
                n_total      = w_total_next;
                n_acc        = 1'b0;
                n_final      = w_final_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '1;
            r_limit <= '0;
            r_map   <= '0;
            r_total <= '0;
            r_final <= '0;
            r_acc   <= 1'b0;
        end else begin
            r_cur   <= n_cur;
            r_limit <= n_limit;
            r_map   <= n_map;
            r_total <= n_total;
            r_final <= n_final;
            r_acc   <= n_acc;
        end
    end

endmodule

FILE: hw/rtl/cfr_cmd_queue.sv
// ============================================================================
// cfr_cmd_queue: two-entry command queue
// Decouples the classifier from the executor; push and pop may coincide.
// ============================================================================
module cfr_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cfr_pkg::t_cmd o_cmd
);
    import cfr_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_count, n_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr    = w_push ? !r_wr : r_wr;
        n_rd    = w_pop ? !r_rd : r_rd;
        n_count = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: hw/rtl/cfr_back.sv
// ============================================================================
// cfr_back: command executor
// Writes and reads the frame buffer, forms the frame length and holds the
// result in an output register until it is popped.
// ============================================================================
module cfr_back #(
    parameter int unsigned MAX_CHUNKS = 256,
    parameter int unsigned CHUNK_SIZE = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_empty,
    input  cfr_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output cfr_pkg::t_result o_result
);
    import cfr_pkg::*;

    localparam int unsigned CHUNK_WORDS = (CHUNK_SIZE + 7) / 8;
    localparam int unsigned BUF_WORDS   = MAX_CHUNKS * CHUNK_WORDS;
    localparam int unsigned MEM_DEPTH   = (BUF_WORDS < (1 << ADDR_W)) ? BUF_WORDS
                                                                       : (1 << ADDR_W);
    localparam int unsigned AW          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic               r_valid;
    t_status            r_status;
    logic [FRAME_W-1:0] r_frame;
    logic [LEN_W-1:0]   r_len;
    logic               r_rd_ok;

    logic               w_take;
    logic               w_rd;
    logic [LEN_W-1:0]   w_len;
    logic [WORD_W-1:0]  w_q;

    assign w_take    = !i_cmd_empty && (!r_valid || i_pop);
    assign o_cmd_pop = w_take;
    assign w_rd      = (i_cmd.status == ST_READ);
    assign w_len     = LEN_W'(32'(i_cmd.limit_m1) * CHUNK_SIZE + 32'(i_cmd.last_bytes));

    cfr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_take && i_cmd.store),
        .i_re    (w_take && w_rd),
        .i_addr  (i_cmd.addr[AW-1:0]),
        .i_wdata (i_cmd.data),
        .o_rdata (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status <= i_cmd.status;
            r_frame  <= i_cmd.done_frame;
            r_len    <= (i_cmd.status == ST_DONE) ? w_len : '0;
            r_rd_ok  <= w_rd && i_cmd.rd_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_empty               = !r_valid;
    assign o_result.status       = r_status;
    assign o_result.done_frame   = r_frame;
    assign o_result.frame_length = r_len;
    assign o_result.read_word    = r_rd_ok ? w_q : '0;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for the chunked frame reassembler
// Feeds chunk words and buffer reads through the push/full side, predicts
// every result with a behavioral copy of the reassembly state, and compares
// each popped result, field by field, with the oldest prediction.
// ============================================================================
module testbench;
    import cfr_pkg::*;

    // The bench runs the block at its default sizes.
    localparam int MAX_CHUNKS  = 256;
    localparam int CHUNK_SIZE  = 1024;
    localparam int CHUNK_WORDS = (CHUNK_SIZE + 7) / 8;
    localparam int BUF_WORDS   = MAX_CHUNKS * CHUNK_WORDS;
    localparam int WORD_TARGET = 1900;

    // Clock, reset and the two handshakes. Every input is known from time zero.
    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push    = 1'b0;
    logic    full;
    t_item   i_item  = '0;
    logic    empty;
    logic    pop     = 1'b0;
    t_result o_result;

    chunked_frame_reassembler #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .CHUNK_SIZE (CHUNK_SIZE)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Synchronous reset, released on a falling edge.
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Behavioral copy of the reassembly state. It starts out in the reset
    // state, which is valid because reset is applied exactly once.
    // ------------------------------------------------------------------------
    logic [31:0] cur_frm        = 32'hFFFF_FFFF;
    logic [15:0] chunk_limit    = '0;
    bit          got_chunk [MAX_CHUNKS];
    int          got_total      = 0;
    logic [10:0] last_chunk_len = '0;
    bit          in_chunk       = 1'b0;
    logic [63:0] frame_mem [BUF_WORDS];
    bit          mem_valid [BUF_WORDS];
    // Buffer addresses holding written data. Reads only ever target these,
    // since a never-written buffer word has no defined contents.
    int          valid_addrs [$];

    // Words waiting to be offered, each with its predicted result, and the
    // predictions of words the block has already taken.
    t_item       pending_words [$];
    t_result     pending_expect [$];
    t_result     reassembly_expect [$];

    int          queued_words    = 0;
    int          results_checked = 0;
    int          mismatch_count  = 0;
    int          frames_done     = 0;
    int          reads_done      = 0;
    int          words_dropped   = 0;
    int          words_stored    = 0;
    int          chunk_order [$];

    // A chunk may be taken when it lies inside both the frame's announced
    // chunk count and the bitmap, and has not been received yet.
    function automatic bit chunk_open(logic [15:0] pos);
        return (pos < chunk_limit) && (pos < MAX_CHUNKS) && !got_chunk[pos[7:0]];
    endfunction

    // Advances the state by one word and returns the result it causes.
    function automatic t_result predict_word(t_item it);
        t_result     r;
        logic [10:0] vb;
        int          off;
        int          keep;
        int          addr;
        int          len;
        logic [63:0] mask;
        r        = '0;
        r.status = ST_DROP;
        if (it.operation == OP_READ) begin
            r.status    = ST_READ;
            r.read_word = frame_mem[it.read_word_address];
            return r;
        end
        // Only the first word of a chunk may open a new frame; a new frame id
        // wipes the bitmap and latches the announced chunk count.
        if (it.word_position == '0) begin
            if (it.frame_number != cur_frm) begin
                cur_frm     = it.frame_number;
                got_chunk   = '{default: 1'b0};
                got_total   = 0;
                chunk_limit = it.chunks_in_frame;
            end
            in_chunk = chunk_open(it.chunk_position);
        end
        // Later words are dropped if the chunk was refused, if the frame id
        // changed mid-chunk, or if their own chunk index is not open.
        if (!in_chunk || it.frame_number != cur_frm || !chunk_open(it.chunk_position))
            return r;
        vb   = (it.valid_bytes > CHUNK_SIZE) ? 11'(CHUNK_SIZE) : it.valid_bytes;
        off  = int'(it.word_position) * 8;
        keep = (int'(vb) > off) ? int'(vb) - off : 0;
        if (keep > 8)
            keep = 8;
        mask = (keep == 8) ? '1 : ((64'd1 << (keep * 8)) - 64'd1);
        addr = int'(it.chunk_position) * CHUNK_WORDS + int'(it.word_position);
        frame_mem[addr] = it.payload_word & mask;
        if (!mem_valid[addr]) begin
            mem_valid[addr] = 1'b1;
            valid_addrs.push_back(addr);
        end
        r.status = ST_ACCEPT;
        if (it.chunk_end) begin
            got_chunk[it.chunk_position[7:0]] = 1'b1;
            got_total++;
            in_chunk = 1'b0;
            if (int'(it.chunk_position) == int'(chunk_limit) - 1)
                last_chunk_len = vb;
            // The completing word reports the frame instead of a plain accept.
            if (got_total == int'(chunk_limit)) begin
                len            = (int'(chunk_limit) - 1) * CHUNK_SIZE + int'(last_chunk_len);
                r.status       = ST_DONE;
                r.done_frame   = cur_frm;
                r.frame_length = len[LEN_W-1:0];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers. Predictions are made as words are queued; the queue
    // is strictly in order, so they match the order in which the block
    // takes the words.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Valid byte counts: mostly in range, with full chunks, short chunks and
    // counts above the chunk size (which the block clamps) mixed in.
    function automatic logic [10:0] pick_bytes();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 11'($urandom_range(1, CHUNK_SIZE));
        if (r < 7)
            return 11'(CHUNK_SIZE);
        if (r < 8)
            return 11'($urandom_range(0, 63));
        return 11'($urandom_range(CHUNK_SIZE + 1, 2047));
    endfunction

    task automatic queue_word(t_item it);
        pending_words.push_back(it);
        pending_expect.push_back(predict_word(it));
        queued_words++;
    endtask

    // A chunk word. The read address field is unused here, so it is random.
    task automatic queue_write(logic [31:0] frame, logic [15:0] pos, logic [15:0] cnt,
                               logic [10:0] vb, logic [6:0] wpos, logic [63:0] data,
                               logic last);
        t_item it;
        it.operation         = OP_WRITE;
        it.frame_number      = frame;
        it.chunk_position    = pos;
        it.chunks_in_frame   = cnt;
        it.valid_bytes       = vb;
        it.word_position     = wpos;
        it.payload_word      = data;
        it.chunk_end         = last;
        it.read_word_address = 15'($urandom);
        queue_word(it);
    endtask

    // A buffer read. The chunk fields are ignored, so they are random.
    task automatic queue_read(int addr);
        t_item it;
        it.operation         = OP_READ;
        it.frame_number      = $urandom;
        it.chunk_position    = 16'($urandom);
        it.chunks_in_frame   = 16'($urandom);
        it.valid_bytes       = 11'($urandom);
        it.word_position     = 7'($urandom);
        it.payload_word      = rand64();
        it.chunk_end         = 1'($urandom);
        it.read_word_address = 15'(addr);
        if (mem_valid[addr])
            queue_word(it);
    endtask

    task automatic read_some(int n);
        for (int k = 0; k < n; k++)
            if (valid_addrs.size() != 0)
                queue_read(valid_addrs[$urandom_range(0, valid_addrs.size() - 1)]);
    endtask

    // One chunk: the first word at position zero, later words at random
    // positions, the end flag on the last one. With mangle set, a word with
    // a flipped frame id is slipped in after the first word.
    task automatic send_chunk(logic [31:0] frame, logic [15:0] pos, logic [15:0] cnt,
                              int nwords, bit mangle);
        logic [10:0] vb;
        vb = pick_bytes();
        for (int w = 0; w < nwords; w++) begin
            if (mangle && w == 1)
                queue_write(frame ^ (32'd1 << $urandom_range(0, 31)), pos, cnt, vb,
                            7'($urandom_range(1, 127)), rand64(), 1'($urandom));
            queue_write(frame, pos, cnt, vb, (w == 0) ? 7'd0 : 7'($urandom_range(1, 127)),
                        rand64(), w == nwords - 1);
        end
    endtask

    // Chunk indexes 0..n-1 in random order.
    task automatic shuffle_positions(int n);
        int j;
        int tmp;
        chunk_order.delete();
        for (int k = 0; k < n; k++)
            chunk_order.push_back(k);
        for (int k = n - 1; k > 0; k--) begin
            j              = $urandom_range(0, k);
            tmp            = chunk_order[k];
            chunk_order[k] = chunk_order[j];
            chunk_order[j] = tmp;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        if (mismatch_count < 40)
            $display("result %0d: %s differs, expected %0h, got %0h",
                     results_checked, what, want, got);
        mismatch_count++;
    endtask

    task automatic check_result(t_result got);
        t_result want;
        if (reassembly_expect.size() == 0) begin
            report_mismatch("unexpected result status", '0, 64'(got.status));
            return;
        end
        want = reassembly_expect.pop_front();
        results_checked++;
        if (got.status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.done_frame !== want.done_frame)
            report_mismatch("done_frame", 64'(want.done_frame), 64'(got.done_frame));
        if (got.frame_length !== want.frame_length)
            report_mismatch("frame_length", 64'(want.frame_length), 64'(got.frame_length));
        if (got.read_word !== want.read_word)
            report_mismatch("read_word", want.read_word, got.read_word);
        case (want.status)
            ST_DONE:   frames_done++;
            ST_READ:   reads_done++;
            ST_DROP:   words_dropped++;
            default:   words_stored++;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. A popped result is
    // checked first; a word taken at this edge moves its prediction into the
    // in-flight queue. word_taken tells the driver what happened at the edge.
    // ------------------------------------------------------------------------
    bit word_taken = 1'b0;

    always @(posedge i_clk) begin
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty)
                check_result(o_result);
            if (push && !full) begin
                word_taken = 1'b1;
                reassembly_expect.push_back(pending_expect.pop_front());
                void'(pending_words.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: words go out in bursts of random length separated by random
    // gaps. Long bursts give stretches without any idle cycle. A word that
    // was offered but not taken stays on the port until the block takes it.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (word_taken && burst_left > 0)
                burst_left--;
            if (!push || word_taken) begin
                if (burst_left == 0) begin
                    push <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(32, 200)
                                                                 : $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                                 : $urandom_range(0, 4);
                    end
                end else if (pending_words.size() != 0) begin
                    push   <= 1'b1;
                    i_item <= pending_words[0];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: pop follows a 16-bit pattern that rotates every cycle and is
    // replaced after a run of random length: always ready, random, sparse or
    // half duty. A pattern is never all zeros, so the stall is bounded.
    // ------------------------------------------------------------------------
    logic [15:0] drain_pattern = 16'hFFFF;
    int          drain_left    = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (drain_left == 0) begin
                drain_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0:       drain_pattern = 16'hFFFF;
                    1:       drain_pattern = 16'($urandom) | 16'h0001;
                    2:       drain_pattern = 16'h0101;
                    default: drain_pattern = 16'hF0F0;
                endcase
            end
            drain_left--;
            drain_pattern = {drain_pattern[14:0], drain_pattern[15]};
            pop <= drain_pattern[15];
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int          r;
        int          n;
        int          cnt;
        logic [31:0] frm_tag;
        bit          big_frame_sent;
        bit          over_limit_sent;
        big_frame_sent  = 1'b0;
        over_limit_sent = 1'b0;

        // Directed part. Right after reset the current frame id is all ones
        // with a zero chunk limit, so a chunk carrying that id is dropped.
        queue_write(32'hFFFF_FFFF, 16'd0, 16'd1, 11'd8, 7'd0, '1, 1'b1);
        // A new frame that announces zero chunks drops everything.
        queue_write(32'h0000_0000, 16'd0, 16'd0, 11'd8, 7'd0, '1, 1'b1);
        // Frame 1 with two chunks. Chunk 1 first, with an oversized byte
        // count that clamps to a full chunk, ending at the last word slot.
        queue_write(32'd1, 16'd1, 16'd2, 11'd2047, 7'd0, '1, 1'b0);
        queue_write(32'd1, 16'd1, 16'd2, 11'd2047, 7'd127, '1, 1'b1);
        // The same chunk again is a duplicate, and chunk 2 is out of range.
        queue_write(32'd1, 16'd1, 16'd2, 11'd8, 7'd0, rand64(), 1'b1);
        queue_write(32'd1, 16'd2, 16'd2, 11'd8, 7'd0, rand64(), 1'b1);
        // A refused chunk keeps refusing its later words.
        queue_write(32'd1, 16'd2, 16'd2, 11'd8, 7'd3, rand64(), 1'b1);
        // Chunk 0 holds eight bytes in its first word and five in the second,
        // with a frame id change slipped in between; it completes the frame.
        queue_write(32'd1, 16'd0, 16'd2, 11'd13, 7'd0, '1, 1'b0);
        queue_write(32'd7, 16'd0, 16'd2, 11'd13, 7'd1, '1, 1'b0);
        queue_write(32'd1, 16'd0, 16'd2, 11'd13, 7'd1, '1, 1'b1);
        queue_read(CHUNK_WORDS);
        queue_read(2 * CHUNK_WORDS - 1);
        queue_read(0);
        queue_read(1);
        // A one-chunk frame with no valid bytes completes with zero length.
        queue_write(32'h8000_0000, 16'd0, 16'd1, 11'd0, 7'd0, '1, 1'b1);
        queue_read(0);
        // More chunks announced than the bitmap holds: the excess is dropped.
        queue_write(32'd2, 16'd256, 16'd300, 11'd64, 7'd0, '1, 1'b1);
        queue_write(32'd2, 16'd255, 16'd300, 11'd64, 7'd0, '1, 1'b1);
        // The largest chunk count and index, then the top buffer word.
        queue_write(32'd3, 16'hFFFF, 16'hFFFF, 11'd64, 7'd0, '1, 1'b1);
        queue_write(32'd3, 16'd255, 16'hFFFF, 11'd2047, 7'd0, '0, 1'b0);
        queue_write(32'd3, 16'd255, 16'hFFFF, 11'd2047, 7'd127, '1, 1'b1);
        queue_read(BUF_WORDS - 1);
        queue_read((MAX_CHUNKS - 1) * CHUNK_WORDS);

        // Random part. Most of it is well-formed frames with random content,
        // chunks in random order, with duplicates, out-of-range chunks, frame
        // id changes inside a chunk and abandoned frames mixed in. Reads and
        // fully random words fill the rest.
        while (queued_words < WORD_TARGET) begin
            r = $urandom_range(0, 99);
            if (!big_frame_sent && queued_words > 800) begin
                // One frame that fills the whole bitmap, one word per chunk.
                big_frame_sent = 1'b1;
                frm_tag        = $urandom;
                shuffle_positions(MAX_CHUNKS);
                foreach (chunk_order[k]) begin
                    queue_write(frm_tag, 16'(chunk_order[k]), 16'(MAX_CHUNKS), pick_bytes(),
                                7'd0, rand64(), 1'b1);
                    if ($urandom_range(0, 15) == 0)
                        read_some(1);
                end
            end else if (!over_limit_sent && queued_words > 1300) begin
                // A frame announcing more chunks than fit; it never completes.
                over_limit_sent = 1'b1;
                frm_tag         = $urandom;
                cnt             = $urandom_range(MAX_CHUNKS + 1, 65535);
                for (int k = 0; k < 8; k++)
                    send_chunk(frm_tag, 16'($urandom_range(MAX_CHUNKS - 6, MAX_CHUNKS + 9)),
                               16'(cnt), $urandom_range(1, 2), 1'b0);
            end else if (r < 70) begin
                frm_tag = $urandom;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                shuffle_positions(n);
                foreach (chunk_order[k]) begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        break;
                    send_chunk(frm_tag, 16'(chunk_order[k]), 16'(n), $urandom_range(1, 4),
                               r < 8);
                    if (r >= 8 && r < 16)
                        send_chunk(frm_tag, 16'(chunk_order[k]), 16'(n),
                                   $urandom_range(1, 3), 1'b0);
                    else if (r >= 16 && r < 21)
                        send_chunk(frm_tag, 16'(n + $urandom_range(0, 3)), 16'(n), 1, 1'b0);
                    if ($urandom_range(0, 4) == 0)
                        read_some($urandom_range(1, 3));
                end
            end else if (r < 85) begin
                read_some($urandom_range(1, 4));
            end else begin
                // Noise: random header fields, which may open a frame of any size.
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    queue_write($urandom, 16'($urandom), 16'($urandom), 11'($urandom),
                                ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom),
                                rand64(), 1'($urandom));
            end
        end

        // Wait for every word to go in and every result to come back, then
        // let the clock run on so that any stray result still shows.
        wait (i_rst_n);
        while (pending_words.size() != 0 || reassembly_expect.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d words checked: %0d stored, %0d dropped, %0d buffer reads",
                 results_checked, words_stored, words_dropped, reads_done);
        $display("%0d frames completed, %0d mismatches", frames_done, mismatch_count);
        if (mismatch_count == 0)
            $display("chunked_frame_reassembler: match");
        else
            $display("chunked_frame_reassembler: mismatch");
        $finish;
    end

    // Watchdog: even with the longest sender gaps and the sparsest pop
    // pattern, a correct run needs only a small fraction of this time.
    initial begin
        #2ms;
        $display("timeout with %0d words still to send and %0d results outstanding",
                 pending_words.size(), reassembly_expect.size());
        $display("chunked_frame_reassembler: mismatch");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_ram.sv
hw/rtl/cfr_front.sv
hw/rtl/cfr_cmd_queue.sv
hw/rtl/cfr_back.sv
hw/rtl/chunked_frame_reassembler.sv
verif/testbench.sv
